// File: rtl/core/poldot_pkg.sv
package poldot_pkg;

  // Default configuration
  localparam int DefDotLimit  = 64;
  localparam int DefCoordW    = 24;

  // Distances and configuration widths
  localparam int DIST_W       = 40;
  localparam int SPACING_W    = 20;
  localparam int MAXDOTS_W    = 7;
  localparam int DOTNUM_W     = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int SCALE_W      = 30;

  localparam logic [SPACING_W-1:0] SPACING_MIN   = 20'd16;
  localparam logic [SPACING_W-1:0] SPACING_RESET = 20'd480;
  localparam logic [MAXDOTS_W-1:0] MAXDOTS_RESET = 7'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_SPACING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DOTS    = 1'b1;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQLD,
    ST_SQ,
    ST_SQRT,
    ST_CHECK,
    ST_SCALE,
    ST_MULLD,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_ENDSEG
  } back_state_t;

endpackage

// File: rtl/core/poldot_queue.sv
module poldot_queue import poldot_pkg::*; #(
  parameter int ENTRY_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [ENTRY_W-1:0] push_data,
  input  logic               pop,
  output logic [ENTRY_W-1:0] pop_data,
  output q_status_t          status
);

  logic [ENTRY_W-1:0] mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r;

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  // Two-entry FIFO between the front and back parts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/poldot_front.sv
module poldot_front import poldot_pkg::*; #(
  parameter int COORD_WIDTH = DefCoordW,
  localparam int MW = COORD_WIDTH + 1,
  localparam int ENTRY_W = 1 + 3 * COORD_WIDTH + 3 * MW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     start_path,
  input  logic [COORD_WIDTH-1:0]   point [3],
  input  q_status_t                q_status,
  output logic                     push,
  output logic [ENTRY_W-1:0]       push_data
);

  logic [COORD_WIDTH-1:0] prev_r [3];
  logic                   have_r;
  logic [MW-1:0]          delta [3];
  logic                   accept, is_start, is_zero;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  // Segment deltas against the previous point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      delta[a] = {point[a][COORD_WIDTH-1], point[a]} - {prev_r[a][COORD_WIDTH-1], prev_r[a]};
    end
  end

  assign is_start = start_path || !have_r;
  assign is_zero  = (delta[0] == '0) && (delta[1] == '0) && (delta[2] == '0);

  // Zero-length segments never reach the back part
  assign push      = accept && (is_start || !is_zero);
  assign push_data = {is_start, prev_r[2], prev_r[1], prev_r[0], delta[2], delta[1], delta[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        prev_r[a] <= '0;
      end
    end else if (accept) begin
      have_r <= 1'b1;
      for (int a = 0; a < 3; a++) begin
        prev_r[a] <= point[a];
      end
    end
  end

endmodule

// File: rtl/core/poldot_back.sv
module poldot_back import poldot_pkg::*; #(
  parameter int DOT_LIMIT   = DefDotLimit,
  parameter int COORD_WIDTH = DefCoordW,
  localparam int MW      = COORD_WIDTH + 1,
  localparam int ENTRY_W = 1 + 3 * COORD_WIDTH + 3 * MW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SPACING_W-1:0]   dot_spacing,
  input  logic [MAXDOTS_W-1:0]   max_dots,
  input  q_status_t              q_status,
  input  logic [ENTRY_W-1:0]     pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] dot [3],
  output logic [DOTNUM_W-1:0]    dot_number,
  output logic                   last_of_run
);

  localparam int SQW   = 2 * MW + 2;
  localparam int RW    = MW + 1;
  localparam int SW    = (RW < SCALE_W) ? RW : SCALE_W;
  localparam int PW    = MW + SW;
  localparam int MAXC  = (PW > SQW) ? PW : SQW;
  localparam int CNT_W = $clog2(MAXC + 1);
  localparam logic [MAXDOTS_W-1:0] LIMIT_CAP = MAXDOTS_W'(DOT_LIMIT);

  back_state_t state_r, state_nxt;

  logic [COORD_WIDTH-1:0] prev_r [3], prev_nxt [3];
  logic [MW-1:0]          d_r [3], d_nxt [3];
  logic [MW-1:0]          mag [3];
  logic [1:0]             axis_r, axis_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SQW-1:0]         sumsq_r, sumsq_nxt, sqa_r, sqa_nxt, rad_r, rad_nxt;
  logic [MW-1:0]          sqb_r, sqb_nxt;
  logic [RW+1:0]          rem_r, rem_nxt;
  logic [RW-1:0]          root_r, root_nxt, len_r, len_nxt;
  logic [RW-1:0]          num_r, num_nxt, den_r, den_nxt;
  logic [PW-1:0]          mula_r, mula_nxt, prod_r, prod_nxt, quo_r, quo_nxt;
  logic [SW-1:0]          mulb_r, mulb_nxt;
  logic [SW-1:0]          drem_r, drem_nxt;
  logic [COORD_WIDTH-1:0] dot_r [3], dot_nxt [3];
  logic [COORD_WIDTH-1:0] odot_r [3], odot_nxt [3];
  logic [DIST_W-1:0]      trav_r, trav_nxt, next_r, next_nxt;
  logic [MAXDOTS_W-1:0]   dp_r, dp_nxt;
  logic                   ov_r, ov_nxt, last_r, last_nxt;
  logic [DOTNUM_W-1:0]    dn_r, dn_nxt;

  logic [MAXDOTS_W-1:0]   limit;
  logic [SPACING_W-1:0]   spacing;
  logic [DIST_W:0]        seg_end, next_sum, trav_sum;
  logic [DIST_W-1:0]      next_sat, trav_sat, gap;
  logic                   dot_here, more_after, cnt_done;
  logic [RW+2:0]          sq_trial, sq_cmp;
  logic [SW:0]            div_trial;
  logic                   div_ge;
  logic [PW-1:0]          prod_fin;
  logic [MW-1:0]          qmag, dot_sum;

  assign limit   = (max_dots > LIMIT_CAP) ? LIMIT_CAP : max_dots;
  assign spacing = (dot_spacing < SPACING_MIN) ? SPACING_MIN : dot_spacing;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = d_r[a][MW-1] ? (~d_r[a] + 1'b1) : d_r[a];
    end
  end

  // Distance bookkeeping with saturation
  assign seg_end  = {1'b0, trav_r} + (DIST_W + 1)'(len_r);
  assign next_sum = {1'b0, next_r} + (DIST_W + 1)'(spacing);
  assign next_sat = next_sum[DIST_W] ? '1 : next_sum[DIST_W-1:0];
  assign trav_sum = seg_end;
  assign trav_sat = trav_sum[DIST_W] ? '1 : trav_sum[DIST_W-1:0];
  assign gap      = (next_r >= trav_r) ? (next_r - trav_r) : '0;
  assign dot_here = (dp_r < limit) && ({1'b0, next_r} <= seg_end);
  assign more_after = ((dp_r + 1'b1) < limit) && ({1'b0, next_sat} <= seg_end);

  // Shared arithmetic steps
  assign sq_trial  = {rem_r[RW:0], rad_r[SQW-1:SQW-2]};
  assign sq_cmp    = {1'b0, root_r, 2'b01};
  assign div_trial = {drem_r, quo_r[PW-1]};
  assign div_ge    = (div_trial >= {1'b0, den_r[SW-1:0]});
  assign prod_fin  = prod_r + (mulb_r[0] ? mula_r : '0);
  // The last quotient bit is settled in the same cycle the position is formed.
  assign qmag      = {quo_r[MW-2:0], div_ge};
  assign dot_sum   = {prev_r[axis_r][COORD_WIDTH-1], prev_r[axis_r]}
                   + (d_r[axis_r][MW-1] ? (~qmag + 1'b1) : qmag);

  always_comb begin
    case (state_r)
      ST_SQ:    cnt_done = (cnt_r == CNT_W'(MW - 1));
      ST_SQRT:  cnt_done = (cnt_r == CNT_W'(RW - 1));
      ST_MUL:   cnt_done = (cnt_r == CNT_W'(SW - 1));
      ST_DIV:   cnt_done = (cnt_r == CNT_W'(PW - 1));
      default:  cnt_done = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty && !pop_data[ENTRY_W-1] && (dp_r < limit)) begin
          state_nxt = ST_SQLD;
        end
      end
      ST_SQLD:  state_nxt = (axis_r == 2'd3) ? ST_SQRT : ST_SQ;
      ST_SQ:    if (cnt_done) state_nxt = ST_SQLD;
      ST_SQRT:  if (cnt_done) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = dot_here ? ST_SCALE : ST_ENDSEG;
      ST_SCALE: if ((den_r >> SCALE_W) == '0) state_nxt = ST_MULLD;
      ST_MULLD: state_nxt = (axis_r == 2'd3) ? ST_EMIT : ST_MUL;
      ST_MUL:   if (cnt_done) state_nxt = ST_DIV;
      ST_DIV:   if (cnt_done) state_nxt = ST_MULLD;
      ST_EMIT:  if (!ov_r || out_ready) state_nxt = ST_CHECK;
      ST_ENDSEG: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign pop = (state_r == ST_IDLE) && !q_status.empty;

  // Datapath and outputs
  always_comb begin
    prev_nxt  = prev_r;
    d_nxt     = d_r;
    dot_nxt   = dot_r;
    odot_nxt  = odot_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r + 1'b1;
    sumsq_nxt = sumsq_r;
    sqa_nxt   = sqa_r;
    sqb_nxt   = sqb_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    len_nxt   = len_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    mula_nxt  = mula_r;
    mulb_nxt  = mulb_r;
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    drem_nxt  = drem_r;
    trav_nxt  = trav_r;
    next_nxt  = next_r;
    dp_nxt    = dp_r;
    ov_nxt    = ov_r && !out_ready;
    last_nxt  = last_r;
    dn_nxt    = dn_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (pop_data[ENTRY_W-1]) begin
            trav_nxt = '0;
            next_nxt = '0;
            dp_nxt   = '0;
          end else begin
            for (int a = 0; a < 3; a++) begin
              d_nxt[a]    = pop_data[a*MW +: MW];
              prev_nxt[a] = pop_data[3*MW + a*COORD_WIDTH +: COORD_WIDTH];
            end
            sumsq_nxt = '0;
            axis_nxt  = 2'd0;
          end
        end
      end
      ST_SQLD: begin
        cnt_nxt = '0;
        if (axis_r == 2'd3) begin
          rad_nxt  = sumsq_r;
          rem_nxt  = '0;
          root_nxt = '0;
        end else begin
          sqa_nxt = SQW'(mag[axis_r]);
          sqb_nxt = mag[axis_r];
        end
      end
      ST_SQ: begin
        // Shift-add square of one axis magnitude
        if (sqb_r[0]) begin
          sumsq_nxt = sumsq_r + sqa_r;
        end
        sqa_nxt = sqa_r << 1;
        sqb_nxt = sqb_r >> 1;
        if (cnt_done) begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      ST_SQRT: begin
        // One root bit per cycle
        rad_nxt = rad_r << 2;
        if (sq_trial >= sq_cmp) begin
          rem_nxt  = (RW + 2)'(sq_trial - sq_cmp);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = (RW + 2)'(sq_trial);
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        if (cnt_done) begin
          len_nxt = root_nxt;
        end
      end
      ST_CHECK: begin
        den_nxt  = len_r;
        num_nxt  = (gap > DIST_W'(len_r)) ? len_r : gap[RW-1:0];
        axis_nxt = 2'd0;
      end
      ST_SCALE: begin
        if ((den_r >> SCALE_W) != '0) begin
          den_nxt = den_r >> 1;
          num_nxt = num_r >> 1;
        end
      end
      ST_MULLD: begin
        cnt_nxt  = '0;
        mula_nxt = PW'(mag[axis_r]);
        mulb_nxt = num_r[SW-1:0];
        prod_nxt = PW'(den_r[SW-1:0] >> 1);
      end
      ST_MUL: begin
        // Shift-add product plus half the divisor for rounding
        prod_nxt = prod_fin;
        mula_nxt = mula_r << 1;
        mulb_nxt = mulb_r >> 1;
        if (cnt_done) begin
          cnt_nxt  = '0;
          quo_nxt  = prod_fin;
          drem_nxt = '0;
        end
      end
      ST_DIV: begin
        // Restoring division, dividend shifts out as quotient shifts in
        if (div_ge) begin
          drem_nxt = SW'(div_trial - {1'b0, den_r[SW-1:0]});
          quo_nxt  = {quo_r[PW-2:0], 1'b1};
        end else begin
          drem_nxt = div_trial[SW-1:0];
          quo_nxt  = {quo_r[PW-2:0], 1'b0};
        end
      end
      ST_EMIT: begin
        // Hand the finished dot to the output register
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          last_nxt = !more_after;
          dn_nxt   = dp_r[DOTNUM_W-1:0];
          odot_nxt = dot_r;
          dp_nxt   = dp_r + 1'b1;
          next_nxt = next_sat;
        end
      end
      ST_ENDSEG: begin
        trav_nxt = trav_sat;
      end
      default: begin
      end
    endcase
    // Finished axis position
    if ((state_r == ST_DIV) && cnt_done) begin
      dot_nxt[axis_r] = dot_sum[COORD_WIDTH-1:0];
      axis_nxt        = axis_r + 2'd1;
    end
  end

  assign out_valid   = ov_r;
  assign dot         = odot_r;
  assign dot_number  = dn_r;
  assign last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      trav_r  <= '0;
      next_r  <= '0;
      dp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      trav_r  <= trav_nxt;
      next_r  <= next_nxt;
      dp_r    <= dp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    d_r     <= d_nxt;
    dot_r   <= dot_nxt;
    odot_r  <= odot_nxt;
    axis_r  <= axis_nxt;
    cnt_r   <= cnt_nxt;
    sumsq_r <= sumsq_nxt;
    sqa_r   <= sqa_nxt;
    sqb_r   <= sqb_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    len_r   <= len_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    mula_r  <= mula_nxt;
    mulb_r  <= mulb_nxt;
    prod_r  <= prod_nxt;
    quo_r   <= quo_nxt;
    drem_r  <= drem_nxt;
    last_r  <= last_nxt;
    dn_r    <= dn_nxt;
  end

endmodule

// File: rtl/core/polyline_uniform_dot_resampler_unit.sv
// Polyline resampler: places dots at equal arc-length spacing along 3D paths.
// Input channel in_*: one beat per path point; in_tuser is start_path, in_tdata
// holds point_x, point_y, point_z (signed Q20.4) from the lowest bit up.
// Output channel out_*: one beat per dot; out_tdata holds dot_x, dot_y, dot_z
// and dot_number, out_tlast marks the last dot caused by one input point.
// Configuration channel cfg_*: index 0 writes dot_spacing (Q.4), index 1 writes
// max_dots; writes are always taken and belong to idle periods.
// A point is taken into a two-entry queue; the back sequencer then works on one
// segment at a time. A segment's squared length is summed with a shift-add
// square per axis and fed to a bit-serial square root, and each dot is worked
// out axis by axis in the shared shift-add multiplier and restoring divider.
// Reset clears the path state and loads dot_spacing 480 and max_dots 32.
// When the receiver stalls, the finished dot waits in the output register while
// the sequencer works out the next dot and then holds; the queue keeps taking
// points until it is full.
module polyline_uniform_dot_resampler_unit import poldot_pkg::*; #(
  parameter int DOT_LIMIT   = DefDotLimit,
  parameter int COORD_WIDTH = DefCoordW,
  localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + DOTNUM_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // point_x, point_y, point_z
  input  logic                 in_tuser,   // start_path
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // dot_x, dot_y, dot_z, dot_number
  output logic                 out_tlast,  // last_of_run
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPACING_W-1:0] cfg_data
);

  localparam int MW      = COORD_WIDTH + 1;
  localparam int ENTRY_W = 1 + 3 * COORD_WIDTH + 3 * MW;

  logic [SPACING_W-1:0]   dot_spacing_r;
  logic [MAXDOTS_W-1:0]   max_dots_r;
  logic [COORD_WIDTH-1:0] point [3];
  logic [COORD_WIDTH-1:0] dot [3];
  logic [DOTNUM_W-1:0]    dot_number;
  q_status_t              q_status;
  logic                   push, pop;
  logic [ENTRY_W-1:0]     push_data, pop_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_spacing_r <= SPACING_RESET;
      max_dots_r    <= MAXDOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DOT_SPACING: dot_spacing_r <= cfg_data;
        CFG_MAX_DOTS:    max_dots_r    <= cfg_data[MAXDOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the input beat
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      point[a] = in_tdata[a*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  poldot_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .start_path (in_tuser),
    .point      (point),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  poldot_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  poldot_back #(
    .DOT_LIMIT   (DOT_LIMIT),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dot_spacing (dot_spacing_r),
    .max_dots    (max_dots_r),
    .q_status    (q_status),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .dot         (dot),
    .dot_number  (dot_number),
    .last_of_run (out_tlast)
  );

  // Pack the result beat
  assign out_tdata = OUT_W'({dot_number, dot[2], dot[1], dot[0]});

endmodule

// File: dv/polyline_uniform_dot_resampler_unit_tb.sv
module polyline_uniform_dot_resampler_unit_tb;
  import poldot_pkg::*;

  localparam int CW             = 24;
  localparam int IN_W           = 72;
  localparam int OUT_W          = 80;
  localparam int LIMIT_DOTS     = 64;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 700;
  localparam int HOLD_CYCLES    = 500;
  localparam longint unsigned DIST_SAT = (64'd1 << 40) - 1;

  // One expected dot: x, y, z packed from the lowest lane up.
  typedef struct packed {
    logic [2:0][CW-1:0]    pos;
    logic [DOTNUM_W-1:0]   num;
    logic                  last;
  } dot_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SPACING_W-1:0] cfg_data = '0;

  polyline_uniform_dot_resampler_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state, mirrors the block's path state and registers.
  longint          prev_pt [3];
  bit              have_prev;
  longint unsigned travelled;
  longint unsigned next_dist;
  int              placed;
  longint unsigned spacing_reg;
  int              max_dots_reg;

  dot_t   dot_q [$];
  int     errors;
  bit     idle_on = 1'b1;
  bit     hold_req = 1'b0;
  longint last_sent [3];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint sx24(input longint v);
    return {{40{v[CW-1]}}, v[CW-1:0]};
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned root;
    longint unsigned rem;
    root = 0;
    rem  = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      if (rem >= ((root << 2) | 64'd1)) begin
        rem  = rem - ((root << 2) | 64'd1);
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned sat_sum(input longint unsigned a, input longint unsigned b);
    return (a + b > DIST_SAT) ? DIST_SAT : a + b;
  endfunction

  // Work out the dots that one accepted point produces and queue them.
  task automatic resample_point(input bit start, input longint p [3]);
    longint          d [3];
    longint unsigned mag [3];
    longint unsigned sumsq, len, step, num, den, q;
    longint          c;
    int              limit, count;
    dot_t            e;
    if (start || !have_prev) begin
      prev_pt   = p;
      have_prev = 1'b1;
      travelled = 0;
      next_dist = 0;
      placed    = 0;
      return;
    end
    limit = (max_dots_reg > LIMIT_DOTS) ? LIMIT_DOTS : max_dots_reg;
    for (int a = 0; a < 3; a++) begin
      d[a]   = p[a] - prev_pt[a];
      mag[a] = (d[a] < 0) ? longint'(-d[a]) : longint'(d[a]);
    end
    if (placed >= limit || (d[0] == 0 && d[1] == 0 && d[2] == 0)) begin
      prev_pt = p;
      return;
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len   = isqrt64(sumsq);
    step  = (spacing_reg < 16) ? 16 : spacing_reg;
    count = 0;
    while (count < LIMIT_DOTS && placed < limit && next_dist <= travelled + len) begin
      num = (next_dist >= travelled) ? next_dist - travelled : 0;
      den = len;
      if (num > den) num = den;
      while (den >= (64'd1 << 30)) begin
        den = den >> 1;
        num = num >> 1;
      end
      for (int a = 0; a < 3; a++) begin
        q = (mag[a] * num + den / 2) / den;
        c = (d[a] < 0) ? prev_pt[a] - longint'(q) : prev_pt[a] + longint'(q);
        e.pos[a] = c[CW-1:0];
      end
      e.num  = placed[DOTNUM_W-1:0];
      e.last = 1'b0;
      dot_q.push_back(e);
      count++;
      placed++;
      next_dist = sat_sum(next_dist, step);
    end
    if (count > 0) dot_q[dot_q.size()-1].last = 1'b1;
    travelled = sat_sum(travelled, len);
    prev_pt   = p;
  endtask

  // Offer one point, optionally after a random gap, and predict once it is taken.
  task automatic send_point(input bit start, input longint x, input longint y, input longint z);
    longint p [3];
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    do @(posedge clk); while (!in_tready);
    p[0] = sx24(x);
    p[1] = sx24(y);
    p[2] = sx24(z);
    last_sent = p;
    resample_point(start, p);
  endtask

  // Stop offering points and wait until the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (dot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPACING_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DOT_SPACING) spacing_reg = val;
    else max_dots_reg = val[MAXDOTS_W-1:0];
    @(posedge clk);
  endtask

  // Next coordinate near the previous one, with rare full-range jumps.
  function automatic longint walk(input longint base);
    longint v;
    case ($urandom_range(0, 49))
      0:       v = sx24($urandom);
      1, 2:    v = base;
      default: begin
        if ($urandom_range(0, 2) == 0) v = base + $urandom_range(0, 128) - 64;
        else v = base + $urandom_range(0, 1600) - 800;
      end
    endcase
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  // Result checker: every accepted dot against the oldest prediction.
  always @(posedge clk) begin
    dot_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (dot_q.size() == 0) begin
        report($sformatf("unexpected dot %h", out_tdata));
      end else begin
        e = dot_q.pop_front();
        for (int a = 0; a < 3; a++)
          if (out_tdata[a*CW +: CW] !== e.pos[a])
            report($sformatf("dot %0d axis %0d got %h want %h",
                             e.num, a, out_tdata[a*CW +: CW], e.pos[a]));
        if (out_tdata[3*CW +: DOTNUM_W] !== e.num)
          report($sformatf("dot number got %0d want %0d", out_tdata[3*CW +: DOTNUM_W], e.num));
        if (out_tlast !== e.last)
          report($sformatf("dot %0d last flag got %b want %b", e.num, out_tlast, e.last));
      end
    end
  end

  // Receiver: random stalls, free-running stretches and the long hold-off.
  initial begin
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any beat.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Path starts, missing previous point, single point, zero length, extremes.
  task automatic test_path_basics();
    send_point(1'b0, 0, 0, 0);
    send_point(1'b0, 480, 0, 0);
    send_point(1'b0, 480, 0, 0);
    send_point(1'b1, 100, 100, 100);
    send_point(1'b1, -8388608, -8388608, -8388608);
    send_point(1'b0, 8388607, 8388607, 8388607);
    send_point(1'b0, 0, 5, -7);
    settle();
  endtask

  // Dot limit at zero, at one, above the hardware limit, and spacing below the minimum.
  task automatic test_dot_limit();
    write_reg(CFG_MAX_DOTS, 20'd0);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b0, 5000, -300, 0);
    settle();
    write_reg(CFG_MAX_DOTS, {13'h1fff, 7'd127});
    write_reg(CFG_DOT_SPACING, 20'd0);
    send_point(1'b1, -20, 40, 7);
    send_point(1'b0, 480, -260, 207);
    send_point(1'b0, -1500, 300, 900);
    send_point(1'b0, 0, 0, 0);
    settle();
    write_reg(CFG_MAX_DOTS, 20'd1);
    write_reg(CFG_DOT_SPACING, 20'd16);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b0, 50, 0, 0);
    send_point(1'b0, 100, 0, 0);
    settle();
  endtask

  // Spacing rewritten between segments of the same path.
  task automatic test_spacing_change();
    write_reg(CFG_MAX_DOTS, 20'd64);
    write_reg(CFG_DOT_SPACING, 20'd480);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b0, 1000, 0, 0);
    settle();
    write_reg(CFG_DOT_SPACING, 20'hfffff);
    send_point(1'b0, 2000, 0, 0);
    settle();
    write_reg(CFG_DOT_SPACING, 20'd16);
    send_point(1'b0, 2100, 0, 0);
    settle();
  endtask

  // Receiver holds off while points keep coming, so the input must stall.
  task automatic test_backpressure();
    write_reg(CFG_DOT_SPACING, 20'd300);
    hold_req = 1'b1;
    send_point(1'b1, 0, 0, 0);
    for (int i = 0; i < 10; i++) send_point(1'b0, walk(last_sent[0]), walk(last_sent[1]),
                                            walk(last_sent[2]));
    settle();
  endtask

  // Random paths under several register settings; the last phase runs without idling.
  task automatic test_random();
    int n;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) idle_on = 1'b0;
      write_reg(CFG_DOT_SPACING, ($urandom_range(0, 5) == 0) ? 20'($urandom)
                                 : 20'($urandom_range(16, 2000)));
      write_reg(CFG_MAX_DOTS, {13'($urandom), 7'($urandom_range(0, 70))});
      n = 0;
      while (n < 105) begin
        len = $urandom_range(1, 12);
        send_point(1'b1, sx24($urandom), sx24($urandom), sx24($urandom));
        for (int i = 1; i < len; i++)
          send_point($urandom_range(0, 30) == 0, walk(last_sent[0]), walk(last_sent[1]),
                     walk(last_sent[2]));
        n += len;
      end
      settle();
    end
  endtask

  initial begin
    errors       = 0;
    have_prev    = 1'b0;
    travelled    = 0;
    next_dist    = 0;
    placed       = 0;
    prev_pt      = '{0, 0, 0};
    last_sent    = '{0, 0, 0};
    spacing_reg  = SPACING_RESET;
    max_dots_reg = MAXDOTS_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_path_basics();
    test_dot_limit();
    test_spacing_change();
    test_backpressure();
    test_random();
    settle();
    if (dot_q.size() != 0) report($sformatf("%0d dots never arrived", dot_q.size()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
